@@ rtl/hue_median_range_classifier_macros.svh @@
// Assertion macros for the hue median range classifier.
`ifndef HUE_MEDIAN_RANGE_CLASSIFIER_MACROS_SVH
`define HUE_MEDIAN_RANGE_CLASSIFIER_MACROS_SVH
`ifndef ASSERT_OFF
`define HMRC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define HMRC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HMRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define HMRC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/hmrc_pkg.sv @@
package hmrc_pkg;
   localparam int COUNT_BITS = 20;
   localparam int HUE_BINS   = 256;
   localparam int NUM_COLORS = 6;
   localparam int HUE_BITS   = 8;
   localparam int MED_BITS   = 9;
   localparam int CLASS_BITS = 3;
   localparam int SAMP_BITS  = 3;
   localparam int ACC_BITS   = COUNT_BITS + HUE_BITS + 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      ST_RUN, ST_CLEAR, ST_WALK, ST_SORT_MED, ST_MID, ST_SORT_MID
   } state_type;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction
endpackage

@@ rtl/hmrc_ram.sv @@
module hmrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/hmrc_data_path.sv @@
module hmrc_data_path
   import hmrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  px_valid,
   input  logic [HUE_BITS-1:0]   px_hue,
   input  logic                  px_last,
   input  logic                  ready,
   input  logic [MED_BITS-1:0]   bounds [8],
   output logic                  res_valid,
   output logic [CLASS_BITS-1:0] res_class,
   output logic                  res_nocal
);
   logic [COUNT_BITS-1:0] hits_ff [NUM_COLORS];
   logic [CLASS_BITS-1:0] rng;
   logic                  hit;

   always_comb begin
      rng = '0;
      hit = 1'b0;
      for (int j = 7; j >= 1; j--) begin
         if (bounds[j] > {1'b0, px_hue}) begin
            hit = 1'b1;
            rng = (j == 7) ? '0 : CLASS_BITS'(j - 1);
         end
      end
   end

   logic [CLASS_BITS-1:0] best_all;
   always_comb begin
      logic [COUNT_BITS-1:0] h [NUM_COLORS];
      for (int k = 0; k < NUM_COLORS; k++) begin
         h[k] = hits_ff[k];
         if (ready && hit && rng == CLASS_BITS'(k)) h[k] = sat_inc(hits_ff[k]);
      end
      best_all = '0;
      for (int k = 0; k < NUM_COLORS; k++) begin
         if (h[best_all] < h[k]) best_all = CLASS_BITS'(k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COLORS; k++) hits_ff[k] <= '0;
         res_valid <= 1'b0;
      end else begin
         res_valid <= px_valid && px_last;
         if (px_valid) begin
            for (int k = 0; k < NUM_COLORS; k++) begin
               if (px_last) begin
                  hits_ff[k] <= '0;
               end else if (ready && hit && rng == CLASS_BITS'(k)) begin
                  hits_ff[k] <= sat_inc(hits_ff[k]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (px_valid && px_last) begin
         res_class <= ready ? best_all : '0;
         res_nocal <= !ready;
      end
   end
endmodule

@@ rtl/hmrc_calib.sv @@
module hmrc_calib
   import hmrc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                px_valid,
   input  logic [HUE_BITS-1:0] px_hue,
   input  logic                px_last,
   output logic                busy,
   output logic                ready,
   output logic [MED_BITS-1:0] bounds [8]
);
   `include "hue_median_range_classifier_macros.svh"

   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [HUE_BITS:0]     idx_ff;
   logic [ACC_BITS-1:0]   acc_ff;
   logic [MED_BITS-1:0]   med_ff;
   logic                  found_ff;
   logic [SAMP_BITS-1:0]  seen_ff;
   logic [MED_BITS-1:0]   b_ff [8];
   logic                  ready_ff;
   logic [2:0]            step_ff;

   // histogram memory: read-modify-write with forwarding of the last write
   logic                  wr_en;
   logic [HUE_BITS-1:0]   wr_addr, rd_addr;
   logic [COUNT_BITS-1:0] wr_data, rd_data, cur;
   logic                  pend_ff;
   logic [HUE_BITS-1:0]   pend_addr_ff;
   logic [COUNT_BITS-1:0] pend_data_ff;
   logic                  upd_ff;
   logic [HUE_BITS-1:0]   upd_addr_ff;
   logic                  upd_last_ff;

   hmrc_ram #(.WIDTH(COUNT_BITS), .DEPTH(HUE_BINS)) u_hist (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign cur = (pend_ff && pend_addr_ff == upd_addr_ff) ? pend_data_ff : rd_data;

   always_comb begin
      rd_addr = (state_ff == ST_WALK) ? idx_ff[HUE_BITS-1:0] : px_hue;
      wr_en   = 1'b0;
      wr_addr = upd_addr_ff;
      wr_data = sat_inc(cur);
      if (state_ff == ST_RUN && upd_ff) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff[HUE_BITS-1:0];
         wr_data = '0;
      end
   end

   assign busy = (state_ff != ST_RUN) || (upd_ff && upd_last_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN:      if (upd_ff && upd_last_ff) state_in = ST_WALK;
         ST_WALK:     if (found_ff || idx_ff == 9'(HUE_BINS)) state_in = ST_CLEAR;
         ST_CLEAR: begin
            if (idx_ff == 9'(HUE_BINS - 1)) begin
               state_in = (!ready_ff && seen_ff == SAMP_BITS'(NUM_COLORS))
                        ? ST_SORT_MED : ST_RUN;
            end
         end
         ST_SORT_MED: if (step_ff == 3'd5) state_in = ST_MID;
         ST_MID:      state_in = ST_SORT_MID;
         ST_SORT_MID: if (step_ff == 3'd5) state_in = ST_RUN;
         default:     state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // histogram memory is swept to zero before the first pixel
         state_ff <= ST_CLEAR;
         upd_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         cnt_ff   <= '0;
         seen_ff  <= '0;
         ready_ff <= 1'b0;
         idx_ff   <= '0;
         step_ff  <= '0;
         found_ff <= 1'b0;
         for (int k = 0; k < 8; k++) b_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         upd_ff   <= px_valid;
         pend_ff  <= wr_en && state_ff == ST_RUN;
         if (px_valid) cnt_ff <= sat_inc(cnt_ff);
         unique case (state_ff)
            ST_RUN: begin
               idx_ff   <= '0;
               acc_ff   <= '0;
               found_ff <= 1'b0;
               med_ff   <= 9'(HUE_BINS);
            end
            ST_WALK: begin
               // bin idx-1 arrives now; idx is candidate median
               if (!found_ff) begin
                  if (idx_ff != '0 && acc_ff + ACC_BITS'(rd_data) >
                      ACC_BITS'(cnt_ff >> 1)) begin
                     found_ff <= 1'b1;
                     med_ff   <= idx_ff;
                  end
                  if (idx_ff != '0) acc_ff <= acc_ff + ACC_BITS'(rd_data);
                  idx_ff <= idx_ff + 1'b1;
               end
               if (state_in == ST_CLEAR) begin
                  idx_ff <= '0;
                  if (seen_ff < SAMP_BITS'(NUM_COLORS) && !ready_ff) begin
                     b_ff[seen_ff] <= found_ff ? med_ff : 9'(HUE_BINS);
                     seen_ff <= seen_ff + 1'b1;
                  end
               end
            end
            ST_CLEAR: begin
               cnt_ff  <= '0;
               idx_ff  <= idx_ff + 1'b1;
               step_ff <= '0;
            end
            ST_SORT_MED, ST_SORT_MID: begin
               // odd-even transposition, one phase per cycle
               step_ff <= step_ff + 1'b1;
               for (int k = 0; k < 5; k++) begin
                  if (k[0] == step_ff[0]) begin
                     if (state_ff == ST_SORT_MED) begin
                        if (b_ff[k+1] < b_ff[k]) begin
                           b_ff[k] <= b_ff[k+1]; b_ff[k+1] <= b_ff[k];
                        end
                     end else begin
                        if (b_ff[k+2] < b_ff[k+1]) begin
                           b_ff[k+1] <= b_ff[k+2]; b_ff[k+2] <= b_ff[k+1];
                        end
                     end
                  end
               end
               if (state_in == ST_RUN) begin
                  b_ff[0]  <= '0;
                  b_ff[7]  <= 9'(HUE_BINS);
                  ready_ff <= 1'b1;
               end
            end
            ST_MID: begin
               step_ff <= '0;
               for (int k = 1; k <= 6; k++) begin
                  logic [MED_BITS:0] hi, d;
                  hi = (k == 6) ? {1'b0, b_ff[0]} + 10'(HUE_BINS) : {1'b0, b_ff[k]};
                  d  = hi - {1'b0, b_ff[k-1]};
                  b_ff[k] <= {1'b0, 8'({1'b0, b_ff[k-1]} + (d >> 1))};
               end
            end
            default: ;
         endcase
         if (state_ff == ST_WALK && !found_ff && idx_ff == 9'(HUE_BINS)) begin
            idx_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      upd_addr_ff  <= px_hue;
      upd_last_ff  <= px_last;
      pend_addr_ff <= wr_addr;
      pend_data_ff <= wr_data;
   end

   assign ready  = ready_ff;
   assign bounds = b_ff;

   `HMRC_ASSERT_IMP(a_no_px_busy, clock, reset, state_ff != ST_RUN, !px_valid)
   `HMRC_ASSERT_NXT(a_ready_sticks, clock, reset, ready_ff, ready_ff)
   `HMRC_ASSERT_IMP(a_seen_max, clock, reset, 1'b1, seen_ff <= SAMP_BITS'(NUM_COLORS))
endmodule

@@ rtl/hue_median_range_classifier.sv @@
// Pixels are taken one per cycle while the input is not stalled. After reset a sweep
// over all 256 bins clears the histogram memory with input stalled. The last pixel of
// a sample square costs a stall while its count is written, then a median walk over
// the 256-bin histogram memory and a clearing sweep, and after the sixth sample a
// sort and midpoint pass; the block stalls input meanwhile. A data square result is
// registered in the data path, then held in an output register.
module hue_median_range_classifier
   import hmrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [HUE_BITS-1:0]   req_hue,
   input  logic                  req_last_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CLASS_BITS-1:0] rsp_color_class,
   output logic                  rsp_not_calibrated
);
   `include "hue_median_range_classifier_macros.svh"

   logic                  busy, ready, acc, res_valid, res_nocal;
   logic [CLASS_BITS-1:0] res_class;
   logic [MED_BITS-1:0]   bounds [8];
   logic                  pend_ff, out_ff;

   // one data result may be in flight or held; stall while one is in flight, or held under rsp_stall
   assign req_stall = busy || pend_ff || (out_ff && rsp_stall);
   assign acc       = req_valid && !req_stall;

   hmrc_calib u_calib (
      .clock, .reset,
      .px_valid(acc && req_opcode == OP_SAMPLE),
      .px_hue(req_hue), .px_last(req_last_pixel),
      .busy, .ready, .bounds
   );

   hmrc_data_path u_data (
      .clock, .reset,
      .px_valid(acc && req_opcode == OP_DATA),
      .px_hue(req_hue), .px_last(req_last_pixel),
      .ready, .bounds, .res_valid, .res_class, .res_nocal
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         out_ff  <= 1'b0;
      end else begin
         pend_ff <= acc && req_opcode == OP_DATA && req_last_pixel;
         if (res_valid) out_ff <= 1'b1;
         else if (!rsp_stall) out_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_color_class    <= res_class;
         rsp_not_calibrated <= res_nocal;
      end
   end

   assign rsp_valid = out_ff;

   `HMRC_ASSERT_IMP(a_no_overwrite, clock, reset, res_valid, !out_ff || !rsp_stall)
   `HMRC_ASSERT_IMP(a_class_range, clock, reset, rsp_valid, rsp_color_class < CLASS_BITS'(NUM_COLORS))
   `HMRC_ASSERT_NXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule
